>>> rtl/linear_probe_hash_map_defines.svh
// assertion macros used by the hash map back end (lphm_back)
`ifndef LINEAR_PROBE_HASH_MAP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_DEFINES_SVH

// cond in this cycle implies prop in the same cycle
`define LPHM_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("lphm assertion failed");

// cond in this cycle implies prop in the next cycle
`define LPHM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lphm assertion failed");

`endif

>>> rtl/lphm_pkg.sv
`timescale 1ns / 1ps

package lphm_pkg;

   localparam int JOB_QUEUE_DEPTH = 2;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] value_out;
      status_type  status;
      logic [7:0]  slot;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } back_state_type;

endpackage

>>> rtl/linear_probe_hash_map.sv
`timescale 1ns / 1ps
// Key-value map, open addressing with linear probing, SLOTS slots.
// Request channel: req_push / req_full, payload req_data (cmd, key, key_hash, value).
//   cmd insert assigns or adds a key, cmd lookup reads its value.
// Response channel: rsp_empty / rsp_pop, payload rsp_data (found, value_out, status, slot),
//   one response per request, in request order.
// After reset the slot table is cleared slot by slot; req_full stays high meanwhile.
// Front stage: when SLOTS is a power of two the start slot is the low hash bits, otherwise
//   the hash is reduced mod SLOTS, 4 bits per cycle.
// A two-entry request queue sits between the front stage and the probe engine.
// Probe engine: an idle state takes the job and starts its first read, then the probe
//   state examines one slot per RAM read until a hit, an empty slot or all slots are tried.
// After the last probe the response is registered in the output register once that is free.
// Insert of a new key is refused (status full) while 4 * count > 3 * SLOTS.
// When rsp_pop stays low the finished response is held, the probe engine waits on it,
//   the queue and front stage fill, and req_full rises.
module linear_probe_hash_map #(
   parameter int SLOTS       = 256,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  lphm_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output lphm_pkg::rsp_type rsp_data
);

   localparam int SW    = $clog2(SLOTS);
   localparam int RQW   = $bits(lphm_pkg::req_type);
   localparam int JOB_W = SW + RQW;

   logic              clearing;
   logic              front_valid, q_full, q_empty, q_pop;
   lphm_pkg::req_type front_req, q_req;
   logic [SW-1:0]     front_start, q_start;
   logic [JOB_W-1:0]  q_din, q_dout;

   lphm_front #(.SLOTS(SLOTS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .hold     (clearing),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .job_valid(front_valid),
      .job_ready(!q_full),
      .job_req  (front_req),
      .job_start(front_start)
   );

   assign q_din   = {front_start, front_req};
   assign q_start = q_dout[JOB_W-1:RQW];
   assign q_req   = q_dout[RQW-1:0];

   lphm_fifo #(.WIDTH(JOB_W), .DEPTH(lphm_pkg::JOB_QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push (front_valid),
      .full (q_full),
      .din  (q_din),
      .pop  (q_pop),
      .empty(q_empty),
      .dout (q_dout)
   );

   lphm_back #(
      .SLOTS      (SLOTS),
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .job_empty(q_empty),
      .job_pop  (q_pop),
      .job_req  (q_req),
      .job_start(q_start),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/lphm_ram.sv
`timescale 1ns / 1ps

module lphm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lphm_fifo.sv
`timescale 1ns / 1ps

module lphm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = cnt_ff == CW'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> rtl/lphm_front.sv
`timescale 1ns / 1ps

module lphm_front #(
   parameter int SLOTS = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     hold,
   input  logic                     req_push,
   output logic                     req_full,
   input  lphm_pkg::req_type        req_data,
   output logic                     job_valid,
   input  logic                     job_ready,
   output lphm_pkg::req_type        job_req,
   output logic [$clog2(SLOTS)-1:0] job_start
);

   localparam int SW        = $clog2(SLOTS);
   localparam int RW        = SW + 1;
   localparam bit IS_POW2   = (SLOTS & (SLOTS - 1)) == 0;
   localparam int STEP_BITS = 4;
   localparam int STEPS     = 32 / STEP_BITS;
   localparam int CW        = $clog2(STEPS + 1);

   logic              busy_ff, busy_in;
   lphm_pkg::req_type item_ff, item_in;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [31:0]       hash_ff, hash_in;
   logic [CW-1:0]     steps_ff, steps_in;
   logic [RW-1:0]     red_r;
   logic [31:0]       red_h;
   logic              done, accept, job_fire;

   assign done      = busy_ff && (IS_POW2 || steps_ff == '0);
   assign job_valid = done;
   assign job_fire  = done && job_ready;
   assign req_full  = hold || (busy_ff && !job_fire);
   assign accept    = req_push && !req_full;
   assign job_req   = item_ff;
   assign job_start = IS_POW2 ? item_ff.key_hash[SW-1:0] : rem_ff;

   // request accept, job handoff and hash mod slot count, restoring reduction msb first
   always_comb begin
      busy_in  = busy_ff;
      item_in  = item_ff;
      rem_in   = rem_ff;
      hash_in  = hash_ff;
      steps_in = steps_ff;
      red_r    = {1'b0, rem_ff};
      red_h    = hash_ff;
      for (int k = 0; k < STEP_BITS; k++) begin
         red_r = {red_r[SW-1:0], red_h[31]};
         red_h = {red_h[30:0], 1'b0};
         if (red_r >= RW'(SLOTS)) begin
            red_r = red_r - RW'(SLOTS);
         end
      end
      if (job_fire) begin
         busy_in = 1'b0;
      end
      if (busy_ff && !done) begin
         rem_in   = red_r[SW-1:0];
         hash_in  = red_h;
         steps_in = steps_ff - 1'b1;
      end
      if (accept) begin
         busy_in  = 1'b1;
         item_in  = req_data;
         rem_in   = '0;
         hash_in  = req_data.key_hash;
         steps_in = CW'(STEPS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      rem_ff   <= rem_in;
      hash_ff  <= hash_in;
      steps_ff <= steps_in;
   end

endmodule

>>> rtl/lphm_back.sv
`timescale 1ns / 1ps
`include "linear_probe_hash_map_defines.svh"

module lphm_back #(
   parameter int SLOTS       = 256,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     clearing,
   input  logic                     job_empty,
   output logic                     job_pop,
   input  lphm_pkg::req_type        job_req,
   input  logic [$clog2(SLOTS)-1:0] job_start,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output lphm_pkg::rsp_type        rsp_data
);

   localparam int SW    = $clog2(SLOTS);
   localparam int KW    = KEY_WIDTH + 1;
   localparam int LIMIT = (3 * SLOTS) / 4;

   lphm_pkg::back_state_type state_ff, state_in;
   logic [SW-1:0]     clr_ff, clr_in;
   lphm_pkg::req_type item_ff, item_in;
   logic [SW-1:0]     start_ff, start_in;
   logic [SW-1:0]     pos_ff, pos_in;
   logic [SW-1:0]     n_ff, n_in;
   logic [SW:0]       cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lphm_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0]          rd_addr, k_waddr, pos_next;
   logic                   k_we, v_we, cnt_en;
   logic [KW-1:0]          k_wdata, k_rd;
   logic [VALUE_WIDTH-1:0] v_wdata, v_rd;
   logic [KEY_WIDTH-1:0]   key_cmp;
   logic                   stop, last, hit, at_limit;

   lphm_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key_ram (
      .clock  (clock),
      .wr_en  (k_we),
      .wr_addr(k_waddr),
      .wr_data(k_wdata),
      .rd_addr(rd_addr),
      .rd_data(k_rd)
   );

   lphm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SLOTS)) u_value_ram (
      .clock  (clock),
      .wr_en  (v_we),
      .wr_addr(pos_ff),
      .wr_data(v_wdata),
      .rd_addr(rd_addr),
      .rd_data(v_rd)
   );

   assign key_cmp   = KEY_WIDTH'(64'(item_ff.key));
   assign v_wdata   = VALUE_WIDTH'(64'(item_ff.value));
   assign stop      = !k_rd[KEY_WIDTH] || (k_rd[KEY_WIDTH-1:0] == key_cmp);
   assign hit       = stop && k_rd[KEY_WIDTH];
   assign last      = n_ff == SW'(SLOTS - 1);
   assign at_limit  = cnt_ff > (SW + 1)'(LIMIT);
   assign pos_next  = (pos_ff == SW'(SLOTS - 1)) ? '0 : pos_ff + 1'b1;
   assign clearing  = state_ff == lphm_pkg::ST_CLEAR;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      start_in     = start_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      job_pop      = 1'b0;
      rd_addr      = pos_ff;
      k_we         = 1'b0;
      k_waddr      = pos_ff;
      k_wdata      = {1'b1, key_cmp};
      v_we         = 1'b0;
      cnt_en       = 1'b0;
      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         lphm_pkg::ST_CLEAR: begin
            k_we    = 1'b1;
            k_waddr = clr_ff;
            k_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SW'(SLOTS - 1)) begin
               state_in = lphm_pkg::ST_IDLE;
            end
         end
         lphm_pkg::ST_IDLE: begin
            rd_addr = job_start;
            if (!job_empty) begin
               job_pop  = 1'b1;
               item_in  = job_req;
               start_in = job_start;
               pos_in   = job_start;
               n_in     = '0;
               state_in = lphm_pkg::ST_PROBE;
            end
         end
         lphm_pkg::ST_PROBE: begin
            if (!stop && !last) begin
               pos_in  = pos_next;
               n_in    = n_ff + 1'b1;
               rd_addr = pos_next;
            end else if (!rsp_valid_in) begin
               rsp_valid_in     = 1'b1;
               rsp_in.found     = hit;
               rsp_in.value_out = '0;
               rsp_in.status    = lphm_pkg::STATUS_OK;
               rsp_in.slot      = stop ? 8'(pos_ff) : 8'(start_ff);
               if (item_ff.cmd == lphm_pkg::CMD_LOOKUP) begin
                  if (hit) begin
                     rsp_in.value_out = 32'(64'(v_rd));
                  end
               end else if (hit) begin
                  v_we = 1'b1;
               end else if (!stop || at_limit) begin
                  rsp_in.status = lphm_pkg::STATUS_FULL;
               end else begin
                  k_we   = 1'b1;
                  v_we   = 1'b1;
                  cnt_en = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = lphm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lphm_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lphm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      start_ff <= start_in;
      pos_ff   <= pos_in;
      n_ff     <= n_in;
      rsp_ff   <= rsp_in;
   end

   `LPHM_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, cnt_ff <= (SW + 1)'(LIMIT + 1))
   `LPHM_ASSERT_IMPLIES(a_no_rsp_in_clear, clock, reset, clearing, !rsp_valid_ff)
   `LPHM_ASSERT_NEXT(a_count_step, clock, reset, cnt_en, cnt_ff == $past(cnt_ff) + 1'b1)
   `LPHM_ASSERT_NEXT(a_pop_starts_probe, clock, reset, job_pop, state_ff == lphm_pkg::ST_PROBE)

endmodule

>>> bench/linear_probe_hash_map_test.sv
`timescale 1ns / 1ps

module linear_probe_hash_map_test;
   import lphm_pkg::*;

   localparam int MAP_SLOTS = 256;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_AT_RESULT = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_REQUESTS = 930;

   typedef struct {
      req_type data;
      bit      drain;
   } pending_request;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   pending_request pending_requests[$];
   rsp_type        expected_rsps[$];

   bit          map_occupied[MAP_SLOTS];
   bit [31:0]   map_key[MAP_SLOTS];
   bit [31:0]   map_value[MAP_SLOTS];
   int unsigned map_entries = 0;

   int unsigned requests_accepted = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;
   int unsigned stall_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   logic [31:0] pool_keys[$];
   logic [31:0] pool_hashes[$];

   linear_probe_hash_map u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_type predict_map_access(req_type r);
      rsp_type     res;
      int unsigned start;
      int unsigned pos;
      bit          stopped;
      bit          hit;
      start = r.key_hash % MAP_SLOTS;
      pos = start;
      stopped = 1'b0;
      for (int n = 0; n < MAP_SLOTS; n++) begin
         if (!stopped) begin
            if (!map_occupied[pos] || map_key[pos] == r.key) begin
               stopped = 1'b1;
            end else begin
               pos = (pos + 1) % MAP_SLOTS;
            end
         end
      end
      if (!stopped) begin
         pos = start;
      end
      hit = stopped && map_occupied[pos];
      res = '0;
      res.found = hit;
      res.status = STATUS_OK;
      res.slot = pos[7:0];
      if (r.cmd == CMD_LOOKUP) begin
         if (hit) begin
            res.value_out = map_value[pos];
         end
      end else if (hit) begin
         map_value[pos] = r.value;
      end else if (!stopped || map_entries * 4 > MAP_SLOTS * 3) begin
         res.status = STATUS_FULL;
      end else begin
         map_occupied[pos] = 1'b1;
         map_key[pos] = r.key;
         map_value[pos] = r.value;
         map_entries++;
      end
      return res;
   endfunction

   task automatic add_request(cmd_type cmd, logic [31:0] key, logic [31:0] key_hash,
                              logic [31:0] value, bit drain);
      pending_request p;
      p.data.cmd = cmd;
      p.data.key = key;
      p.data.key_hash = key_hash;
      p.data.value = value;
      p.drain = drain;
      pending_requests.push_back(p);
   endtask

   // request driver
   always @(posedge clock) begin
      bit next_push;
      bit may_send;
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
      end else begin
         next_push = req_push;
         if (req_push && !req_full) begin
            expected_rsps.push_back(predict_map_access(req_data));
            requests_accepted++;
            next_push = 1'b0;
         end
         if (!next_push && pending_requests.size() > 0) begin
            may_send = (requests_accepted >= 300 && requests_accepted < 450) ||
                       $urandom_range(0, 99) >= 18;
            if (pending_requests[0].drain && requests_accepted != results_seen) begin
               may_send = 1'b0;
            end
            if (may_send) begin
               req_data <= pending_requests[0].data;
               pending_requests.pop_front();
               next_push = 1'b1;
            end
         end
         req_push <= next_push;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen <= results_seen + 1;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d actual %0d", want.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.value_out !== want.value_out) begin
                  $error("value_out: expected %h actual %h", want.value_out,
                         rsp_data.value_out);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.slot !== want.slot) begin
                  $error("slot: expected %0d actual %0d", want.slot, rsp_data.slot);
                  mismatches++;
               end
            end
         end
         if (!hold_done && results_seen == HOLD_AT_RESULT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= (results_seen >= 600 && results_seen < 750) ||
                       $urandom_range(0, 99) >= 18;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int unsigned pick;
      int unsigned idx;
      logic [31:0] key;
      logic [31:0] key_hash;

      // empty table, wraparound past the last slot, assign and lookups
      add_request(CMD_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
      add_request(CMD_INSERT, 32'h0, 32'h0, 32'h0, 1'b0);
      add_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_request(CMD_INSERT, 32'h1, 32'h0000_01FF, 32'hA5A5_A5A5, 1'b0);
      add_request(CMD_INSERT, 32'h2, 32'h0000_00FF, 32'h5A5A_5A5A, 1'b0);
      add_request(CMD_LOOKUP, 32'h2, 32'h0000_00FF, 32'h0, 1'b0);
      add_request(CMD_LOOKUP, 32'h1, 32'hFFFF_FFFF, 32'h0, 1'b0);
      add_request(CMD_LOOKUP, 32'h3, 32'h0000_00FF, 32'h0, 1'b0);
      add_request(CMD_INSERT, 32'h0, 32'h0, 32'h1234_5678, 1'b0);
      add_request(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0);
      add_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
      add_request(CMD_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
      add_request(CMD_LOOKUP, 32'h0, 32'h8000_0000, 32'h0, 1'b0);
      add_request(CMD_LOOKUP, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0);
      add_request(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FF00, 32'h8000_0001, 1'b0);
      add_request(CMD_LOOKUP, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
      pool_keys = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h8000_0000};
      pool_hashes = '{32'h0, 32'hFFFF_FFFF, 32'h0000_01FF, 32'h0000_00FF, 32'h7FFF_FF00};

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            key = $urandom();
            key_hash = $urandom();
            // dense cluster near the top of the table to force long probes and wraparound
            if ($urandom_range(0, 99) < 15) begin
               key_hash[7:0] = 8'hF0 + 8'($urandom_range(0, 15));
            end
            pool_keys.push_back(key);
            pool_hashes.push_back(key_hash);
            add_request(CMD_INSERT, key, key_hash, $urandom(), i == 0 || i == 500);
         end else if (pick < 50) begin
            idx = $urandom_range(0, pool_keys.size() - 1);
            add_request(CMD_INSERT, pool_keys[idx], pool_hashes[idx], $urandom(),
                        i == 0 || i == 500);
         end else if (pick < 80) begin
            idx = $urandom_range(0, pool_keys.size() - 1);
            add_request(CMD_LOOKUP, pool_keys[idx], pool_hashes[idx], $urandom(),
                        i == 0 || i == 500);
         end else if (pick < 90) begin
            add_request(CMD_LOOKUP, $urandom(), $urandom(), $urandom(), i == 0 || i == 500);
         end else begin
            idx = $urandom_range(0, pool_keys.size() - 1);
            add_request(cmd_type'($urandom_range(0, 1)), pool_keys[idx], $urandom(),
                        $urandom(), i == 0 || i == 500);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_requests.size() > 0 || req_push || results_seen != requests_accepted) begin
         @(negedge clock);
      end
      repeat (40) @(posedge clock);
      @(negedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d responses never arrived", expected_rsps.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lphm_pkg.sv
rtl/lphm_ram.sv
rtl/lphm_fifo.sv
rtl/lphm_front.sv
rtl/lphm_back.sv
rtl/linear_probe_hash_map.sv
bench/linear_probe_hash_map_test.sv
